// ----- rtl/crc16_deframer_pkg.sv -----
// Package with the shared constants, status codes and CRC byte update of the frame deframer.
`timescale 1ns / 1ps

package crc16_deframer_pkg;

   // Frame limits.
   localparam logic [7:0] MAX_FRAME_BYTES = 8'd255;
   localparam logic [7:0] MIN_FRAME_BYTES = 8'd5;
   localparam logic [7:0] PAYLOAD_START   = 8'd3;

   // Header positions.
   localparam logic [7:0] POS_ID      = 8'd0;
   localparam logic [7:0] POS_LENGTH  = 8'd1;
   localparam logic [7:0] POS_PAYLOAD = 8'd2;

   // CRC-16/XMODEM constants.
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP  = 16'h8000;

   // Result item layout.
   localparam int RSP_DATA_WIDTH = 48;

   // Status codes reported on the last byte of a frame.
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_LENGTH   = 2'd1,
      STATUS_CRC      = 2'd2
   } frame_status_type;

   // One byte of CRC update, most significant bit first, eight shift steps.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- rtl/crc16_packet_deframer.sv -----
// Top level of the CRC-16 frame deframer: header capture, payload pass-through and frame check.
//
// Input channel (req_): one frame byte per item in req_tdata, req_tlast high on the
// frame's last byte. Result channel (rsp_): one item for every payload byte and one
// for the last byte of each frame (a last byte that is also payload gives a single
// item with both flags). Bytes that are header or CRC only give no item.
// Frame layout: id, declared total length, payload length, payload, then the
// CRC-16/XMODEM over all bytes but the final two, low byte first.
// Each result item is registered in the output register from its accepted byte. Throughput is
// one byte per cycle while the receiver takes items; the CRC update is an eight-step
// shift network that sits between the frame state registers and the output register.
// Reset clears the frame state and empties the output register. When the receiver
// stalls, the output register holds its item and req_tready falls until the item
// is taken; the cycle it is taken, a new byte can enter.
`timescale 1ns / 1ps

module crc16_packet_deframer
   import crc16_deframer_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // Input channel.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] rx_byte
   input  logic                      req_tlast,   // frame_end
   // Result channel.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [7:0] payload_byte, [15:8] payload_index, [17:16] frame_status,
   // [25:18] packet_id, [33:26] payload_count, [41:34] received_length, [47:42] zero
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                      rsp_tuser,   // payload_valid
   output logic                      rsp_tlast    // status_valid
);

   // Frame state.
   logic [7:0]  count_ff, count_in;
   logic        over_ff, over_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  tail0_ff, tail0_in;
   logic [7:0]  tail1_ff, tail1_in;
   logic [7:0]  id_ff, id_in;
   logic [7:0]  dlen_ff, dlen_in;
   logic [7:0]  dpay_ff, dpay_in;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                      rsp_user_ff, rsp_user_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic             accept;
   logic             placed;
   logic             pay;
   logic [7:0]       pidx;
   logic [15:0]      rx_crc;
   frame_status_type status;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Per-byte frame update and result item.
   always_comb begin
      count_in    = count_ff;
      over_in     = over_ff;
      crc_in      = crc_ff;
      tail0_in    = tail0_ff;
      tail1_in    = tail1_ff;
      id_in       = id_ff;
      dlen_in     = dlen_ff;
      dpay_in     = dpay_ff;
      pay         = 1'b0;
      pidx        = 8'd0;
      rx_crc      = {req_tdata, tail1_ff};
      status      = STATUS_OK;
      placed      = !over_ff && (count_ff < MAX_FRAME_BYTES);

      // The CRC trails the input by two bytes so the CRC field stays out of it.
      if ((count_ff >= POS_PAYLOAD) || over_ff) begin
         crc_in = crc_feed(crc_ff, tail0_ff);
      end

      if (placed) begin
         if (count_ff == POS_ID) begin
            id_in = req_tdata;
         end else if (count_ff == POS_LENGTH) begin
            dlen_in = req_tdata;
         end else if (count_ff == POS_PAYLOAD) begin
            dpay_in = req_tdata;
         end
         if ((count_ff >= PAYLOAD_START) && ((count_ff - PAYLOAD_START) < dpay_ff)) begin
            pay  = 1'b1;
            pidx = count_ff - PAYLOAD_START;
         end
         count_in = count_ff + 8'd1;
      end else begin
         over_in = 1'b1;
      end

      // Frame check on the last byte.
      if (over_in || (count_in < MIN_FRAME_BYTES) || (dlen_in != count_in)) begin
         status = STATUS_LENGTH;
      end else if (crc_in != rx_crc) begin
         status = STATUS_CRC;
      end

      rsp_user_in = pay;
      rsp_last_in = req_tlast;
      rsp_data_in = '0;
      if (pay) begin
         rsp_data_in[7:0]  = req_tdata;
         rsp_data_in[15:8] = pidx;
      end
      if (req_tlast) begin
         rsp_data_in[17:16] = status;
         rsp_data_in[25:18] = id_in;
         rsp_data_in[33:26] = dpay_in;
         rsp_data_in[41:34] = count_in;
      end

      // The last byte clears the frame; otherwise the byte enters the tail.
      if (req_tlast) begin
         count_in = 8'd0;
         over_in  = 1'b0;
         crc_in   = 16'h0000;
         tail0_in = 8'd0;
         tail1_in = 8'd0;
         id_in    = 8'd0;
         dlen_in  = 8'd0;
         dpay_in  = 8'd0;
      end else begin
         tail0_in = tail1_ff;
         tail1_in = req_tdata;
      end
   end

   // Output register valid.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept && (pay || req_tlast)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 8'd0;
         over_ff  <= 1'b0;
         crc_ff   <= 16'h0000;
         tail0_ff <= 8'd0;
         tail1_ff <= 8'd0;
         id_ff    <= 8'd0;
         dlen_ff  <= 8'd0;
         dpay_ff  <= 8'd0;
      end else if (accept) begin
         count_ff <= count_in;
         over_ff  <= over_in;
         crc_ff   <= crc_in;
         tail0_ff <= tail0_in;
         tail1_ff <= tail1_in;
         id_ff    <= id_in;
         dlen_ff  <= dlen_in;
         dpay_ff  <= dpay_in;
      end
   end

   // Result item registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (pay || req_tlast)) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/crc16_deframer_checker.sv -----
// Port-level checker for the CRC-16 frame deframer and its bind to the top level.
`timescale 1ns / 1ps

module crc16_deframer_checker
   import crc16_deframer_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic                      rsp_tuser,
   input logic                      rsp_tlast
);

   // A stalled result item holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result item changed");

   // Every result item is either a payload byte or a frame end.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser || rsp_tlast)
      else $error("result item carries neither payload nor status");

   // A frame end reports a defined status code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (rsp_tdata[17:16] == STATUS_OK)
         || (rsp_tdata[17:16] == STATUS_LENGTH) || (rsp_tdata[17:16] == STATUS_CRC))
      else $error("undefined frame status");

   // Status fields stay zero on a payload-only item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[41:16] == '0)
      else $error("status fields set without frame end");

   // Payload fields stay zero on a status-only item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[15:0] == '0)
      else $error("payload fields set without payload byte");

endmodule

bind crc16_packet_deframer crc16_deframer_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
